[rtl/core/b32d_pkg.sv]
// package for the base32 decoder: character constants, status codes and the
// classified character type passed from front to back
// no dependencies
package b32d_pkg;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
	localparam logic [7:0] CHAR_TWO     = 8'h32;  // '2'
	localparam logic [7:0] CHAR_SEVEN   = 8'h37;  // '7'
	localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
	localparam logic [4:0] DIGIT_BASE   = 5'd26;

	localparam logic [3:0] PAD_MAX      = 4'd15;
	localparam logic [3:0] PAD_LIMIT    = 4'd8;
	localparam logic [2:0] POS_LAST     = 3'd7;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_LEN   = 2'd1;
	localparam logic [1:0] STATUS_BAD_PAD   = 2'd2;
	localparam logic [1:0] STATUS_EXCESS_PAD = 2'd3;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic       is_sym;   // character is in the alphabet
		logic [4:0] sym;      // 5-bit value when is_sym
		logic       is_pad;   // character is '='
		logic       last;     // final character of the string
	} b32d_item_t;

endpackage

[rtl/core/base32_decoder.sv]
// top level of the base32 decoder: front end, queue and back end
// depends on b32d_pkg, b32d_front, b32d_queue, b32d_back
//
// Decodes a base32 (RFC 4648 alphabet, upper case only) string one character
// per request and returns exactly one result per character: a byte when that
// character completed one, and on the character marked last_char a status
// (0 ok, 1 length not a multiple of 8, 2 non-pad in the tail, 3 eight or more
// pads). Bytes of a failed string are still delivered; drop them unless the
// status is ok. The block takes one character every cycle while out_ready
// holds; a result passes from the front register through the queue to the
// output register of the back end, whose bit-buffer update keeps that rate.
module base32_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       string_end,
	output logic [1:0] status
);
	import b32d_pkg::*;

	logic       f_valid;
	logic       f_ready;
	b32d_item_t f_item;
	logic       q_valid;
	logic       q_ready;
	b32d_item_t q_item;

	b32d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.last_char  (last_char),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	b32d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	b32d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.string_end (string_end),
		.status     (status)
	);

endmodule

[rtl/core/b32d_front.sv]
// front end: accepts characters and classifies them into a registered item
// depends on b32d_pkg
module b32d_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output logic               item_valid,
	input  logic               item_ready,
	output b32d_pkg::b32d_item_t item
);
	import b32d_pkg::*;

	logic       valid_s1;
	b32d_item_t item_s1;
	b32d_item_t cls;
	logic       is_upper;
	logic       is_digit;
	logic [7:0] upper_off;
	logic [7:0] digit_off;

	always_comb begin
		is_upper  = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z);
		is_digit  = (char_code >= CHAR_TWO) && (char_code <= CHAR_SEVEN);
		upper_off = char_code - CHAR_UPPER_A;
		digit_off = char_code - CHAR_TWO;
		cls.is_sym = is_upper || is_digit;
		cls.sym    = is_upper ? upper_off[4:0] : (DIGIT_BASE + digit_off[4:0]);
		cls.is_pad = (char_code == CHAR_PAD);
		cls.last   = last_char;
	end

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

[rtl/core/b32d_queue.sv]
// short queue of classified characters between front and back
// depends on b32d_pkg
module b32d_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  b32d_pkg::b32d_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output b32d_pkg::b32d_item_t pop_item
);
	import b32d_pkg::*;

	b32d_item_t         mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/core/b32d_back.sv]
// back end: bit buffer, padding tracking, status and the output register
// depends on b32d_pkg
module b32d_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  b32d_pkg::b32d_item_t item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         data_byte,
	output logic               byte_valid,
	output logic               string_end,
	output logic [1:0]         status
);
	import b32d_pkg::*;

	logic [11:0] buf_q;
	logic [3:0]  cnt_q;
	logic [2:0]  pos_q;
	logic        in_pad_q;
	logic [3:0]  pad_cnt_q;
	logic        bad_pad_q;

	logic        out_valid_q;
	logic [7:0]  data_byte_q;
	logic        byte_valid_q;
	logic        string_end_q;
	logic [1:0]  status_q;

	logic        take;
	logic [11:0] shifted;
	logic [3:0]  cnt_sum;
	logic [3:0]  cnt_rem;
	logic [11:0] buf_n;
	logic [3:0]  cnt_n;
	logic        in_pad_n;
	logic [3:0]  pad_cnt_n;
	logic        bad_pad_n;
	logic [7:0]  byte_n;
	logic        byte_valid_n;
	logic [1:0]  status_n;

	assign item_ready = !out_valid_q || out_ready;
	assign take       = item_valid && item_ready;

	always_comb begin
		// buffer holds at most 7 pending bits between characters
		shifted      = {buf_q[6:0], item.sym};
		cnt_sum      = cnt_q + 4'd5;
		cnt_rem      = cnt_sum - 4'd8;
		buf_n        = buf_q;
		cnt_n        = cnt_q;
		in_pad_n     = in_pad_q;
		pad_cnt_n    = pad_cnt_q;
		bad_pad_n    = bad_pad_q;
		byte_n       = 8'd0;
		byte_valid_n = 1'b0;
		if (!in_pad_q && item.is_sym) begin
			if (cnt_sum >= 4'd8) begin
				byte_n       = 8'(shifted >> cnt_rem[2:0]);
				byte_valid_n = 1'b1;
				buf_n        = shifted & ~(12'hFFF << cnt_rem[2:0]);
				cnt_n        = cnt_rem;
			end else begin
				buf_n = shifted;
				cnt_n = cnt_sum;
			end
		end else begin
			in_pad_n = 1'b1;
			if (pad_cnt_q != PAD_MAX) begin
				pad_cnt_n = pad_cnt_q + 4'd1;
			end
			if (!item.is_pad) begin
				bad_pad_n = 1'b1;
			end
		end
		status_n = STATUS_OK;
		if (item.last) begin
			if (pos_q != POS_LAST) begin
				status_n = STATUS_BAD_LEN;
			end else if (bad_pad_n) begin
				status_n = STATUS_BAD_PAD;
			end else if (pad_cnt_n >= PAD_LIMIT) begin
				status_n = STATUS_EXCESS_PAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q       <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			in_pad_q    <= 1'b0;
			pad_cnt_q   <= '0;
			bad_pad_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				out_valid_q <= item_valid;
			end
			if (take) begin
				if (item.last) begin
					// string done: back to a clean state
					buf_q     <= '0;
					cnt_q     <= '0;
					pos_q     <= '0;
					in_pad_q  <= 1'b0;
					pad_cnt_q <= '0;
					bad_pad_q <= 1'b0;
				end else begin
					buf_q     <= buf_n;
					cnt_q     <= cnt_n;
					pos_q     <= pos_q + 3'd1;
					in_pad_q  <= in_pad_n;
					pad_cnt_q <= pad_cnt_n;
					bad_pad_q <= bad_pad_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_byte_q  <= byte_n;
			byte_valid_q <= byte_valid_n;
			string_end_q <= item.last;
			status_q     <= status_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_byte  = data_byte_q;
	assign byte_valid = byte_valid_q;
	assign string_end = string_end_q;
	assign status     = status_q;

endmodule

[test/base32_decode_checker.sv]
// checker for the base32 decoder: watches both channels, decodes each accepted
// request on its own and compares every result field against that decode
// depends on b32d_pkg
`timescale 1ns / 1ps

module base32_decode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       string_end,
	input  logic [1:0] status,
	output int         mismatches,
	output int         pending
);
	import b32d_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       data_ok;
		logic       done;
		logic [1:0] code;
	} decoded_t;

	logic [11:0] buf_bits;
	logic [3:0]  held_bits;
	logic [2:0]  char_pos;
	logic        in_tail;
	logic [3:0]  tail_len;
	logic        tail_bad;

	decoded_t decoded_q[$];
	decoded_t want;

	function automatic void clear_decoder();
		buf_bits  = '0;
		held_bits = '0;
		char_pos  = '0;
		in_tail   = 1'b0;
		tail_len  = '0;
		tail_bad  = 1'b0;
	endfunction

	function automatic decoded_t decode_char(input logic [7:0] c, input logic fin);
		decoded_t   r;
		logic [4:0] v;
		logic       is_sym;
		r      = '0;
		v      = '0;
		is_sym = 1'b1;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
			v = 5'(c - CHAR_UPPER_A);
		else if (c >= CHAR_TWO && c <= CHAR_SEVEN)
			v = DIGIT_BASE + 5'(c - CHAR_TWO);
		else
			is_sym = 1'b0;

		if (!in_tail && is_sym) begin
			buf_bits  = {buf_bits[6:0], v};
			held_bits = held_bits + 4'd5;
			if (held_bits >= 4'd8) begin
				held_bits = held_bits - 4'd8;
				r.data    = 8'(buf_bits >> held_bits);
				r.data_ok = 1'b1;
				buf_bits  = buf_bits & ((12'd1 << held_bits) - 12'd1);
			end
		end else begin
			// anything outside the alphabet opens the tail, alphabet chars included after that
			in_tail = 1'b1;
			if (tail_len != PAD_MAX)
				tail_len = tail_len + 4'd1;
			if (c != CHAR_PAD)
				tail_bad = 1'b1;
		end

		if (fin) begin
			r.done = 1'b1;
			if (char_pos != POS_LAST)
				r.code = STATUS_BAD_LEN;
			else if (tail_bad)
				r.code = STATUS_BAD_PAD;
			else if (tail_len >= PAD_LIMIT)
				r.code = STATUS_EXCESS_PAD;
			else
				r.code = STATUS_OK;
			clear_decoder();
		end else begin
			char_pos = char_pos + 3'd1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int wanted);
		$display("%0t mismatch on %s: got %0h, wanted %0h", $realtime, what, got, wanted);
		mismatches++;
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_decoder();
			decoded_q.delete();
			pending <= 0;
		end else begin
			// queue first so a same-edge result would still find its request
			if (in_valid && in_ready)
				decoded_q = {decoded_q, decode_char(char_code, last_char)};
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch("result with no request", data_byte, 0);
				end else begin
					want = decoded_q.pop_front();
					if (data_byte !== want.data)
						report_mismatch("data_byte", data_byte, want.data);
					if (byte_valid !== want.data_ok)
						report_mismatch("byte_valid", byte_valid, want.data_ok);
					if (string_end !== want.done)
						report_mismatch("string_end", string_end, want.done);
					if (status !== want.code)
						report_mismatch("status", status, want.code);
				end
			end
			pending <= decoded_q.size();
		end
	end

endmodule

[test/tb_base32_decoder.sv]
// testbench top for the base32 decoder: reset, clock, request and result
// stimulus with random stalls, and the verdict
// depends on b32d_pkg, base32_decoder and base32_decode_checker
`timescale 1ns / 1ps

module tb_base32_decoder;
	import b32d_pkg::*;

	localparam int ITEM_TARGET = 1550;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic [7:0] char_q_t[$];

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_code;
	logic       last_char;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       string_end;
	logic [1:0] status;

	int mismatches;
	int pending;
	int items_sent;
	int cycle_count;
	int in_idle_pct;
	int out_idle_pct;

	base32_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.string_end (string_end),
		.status     (status)
	);

	base32_decode_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.string_end (string_end),
		.status     (status),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stall bursts while out_idle_pct is nonzero
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && $urandom_range(0, 99) < out_idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic logic [7:0] rand_symbol();
		int v;
		v = $urandom_range(0, 31);
		return (v < 26) ? CHAR_UPPER_A + 8'(v) : CHAR_TWO + 8'(v - 26);
	endfunction

	function automatic logic [7:0] rand_non_pad();
		logic [7:0] c;
		do begin
			// lower case half the time, anything else otherwise
			c = $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A)) : 8'($urandom_range(0, 255));
		end while (c == CHAR_PAD);
		return c;
	endfunction

	function automatic char_q_t from_text(input string t);
		char_q_t s;
		for (int i = 0; i < t.len(); i++)
			s = {s, 8'(t[i])};
		return s;
	endfunction

	function automatic char_q_t padded_string(input int len, input int pads);
		char_q_t s;
		for (int i = 0; i < len; i++)
			s = {s, (i < len - pads) ? rand_symbol() : CHAR_PAD};
		return s;
	endfunction

	function automatic char_q_t make_string();
		char_q_t s;
		int      kind;
		int      len;
		int      pads;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			// well formed, status ok
			s = padded_string(8 * $urandom_range(1, 3), $urandom_range(0, 7));
		end else if (kind < 70) begin
			len = $urandom_range(1, 30);
			if (len % 8 == 0)
				len++;
			pads = $urandom_range(0, 7);
			s = padded_string(len, pads > len ? len : pads);
		end else if (kind < 80) begin
			// one non-pad character somewhere in the tail
			pads = $urandom_range(1, 7);
			len  = 8 * $urandom_range(1, 3);
			s = padded_string(len, pads);
			s[len - 1 - $urandom_range(0, pads - 1)] = rand_non_pad();
		end else if (kind < 88) begin
			len = 8 * $urandom_range(2, 3);
			s = padded_string(len, $urandom_range(8, len));
		end else begin
			len = $urandom_range(1, 16);
			for (int i = 0; i < len; i++)
				s = {s, 8'($urandom_range(0, 255))};
		end
		return s;
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin);
		if ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		last_char <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input char_q_t s);
		foreach (s[i])
			send_char(s[i], i == s.size() - 1);
	endtask

	initial begin
		char_q_t s;
		int      phase;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		char_code    <= '0;
		last_char    <= 1'b0;
		items_sent   = 0;
		cycle_count  = 0;
		in_idle_pct  = 15;
		out_idle_pct = 15;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// alphabet extremes with leftover bits, then all pads, then a tail full of junk
		send_text(from_text("AZ27===="));
		send_text(from_text("========"));
		s = from_text("AB?=Ca?=");
		s[2] = 8'h00;
		s[6] = 8'hFF;
		send_text(s);
		// short and bad tail together: length takes priority
		send_text(from_text("z"));

		while (items_sent < ITEM_TARGET) begin
			phase = items_sent * 4 / ITEM_TARGET;
			case (phase)
				0: begin
					in_idle_pct  = 15;
					out_idle_pct = 15;
				end
				1: begin
					in_idle_pct  = 25;
					out_idle_pct = 0;
				end
				2: begin
					in_idle_pct  = 0;
					out_idle_pct = 30;
				end
				default: begin
					in_idle_pct  = 0;
					out_idle_pct = 0;
				end
			endcase
			send_text(make_string());
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
